// ===== src/blm_pkg.sv =====
// ----------------------------------------------------------------------------
// blm_pkg
// shared constants, state encoding and controller/datapath command types
// ----------------------------------------------------------------------------
package blm_pkg;

    localparam int MAX_LEN   = 64;
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int IDX_W     = $clog2(MAX_LEN);
    localparam int TAB_DEPTH = MAX_LEN * (MAX_LEN + 1) / 2;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);
    localparam int PROB_W    = 17;
    localparam int VAL_W     = 32;
    localparam int VLEN_W    = 7;
    localparam int PROD_W    = PROB_W + VAL_W;
    localparam int ACC_W     = PROD_W + IDX_W;
    localparam int RND_W     = ACC_W - 16;
    localparam int ADDR_W    = 3;

    localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(65536);
    localparam logic [ACC_W-1:0]  HALF_Q16 = ACC_W'(32768);

    localparam logic REG_KEEP_PROB = 1'b0;
    localparam logic REG_VEC_LEN   = 1'b1;

    typedef enum logic [3:0] {
        S_BINIT,
        S_BRD,
        S_BM0,
        S_BM1,
        S_BM2,
        S_IDLE,
        S_MRD,
        S_MMUL,
        S_MACC,
        S_MOUT
    } t_state;

    typedef struct packed {
        logic in_en;
        logic b_init;
        logic b_rd_sel;
        logic b_mul0;
        logic b_mul1;
        logic b_wr;
        logic m_start;
        logic m_mul;
        logic m_acc;
        logic m_out;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic kp_wr;
        logic vec_done;
        logic row_last;
        logic table_last;
        logic from_last;
        logic out_last;
        logic slot_free;
    } t_sts;

endpackage

// ===== src/blm_if.sv =====
// ----------------------------------------------------------------------------
// blm stream interfaces
// valid/ready channels for input elements and result beats
// ----------------------------------------------------------------------------
interface blm_elem_if;
    logic        valid;
    logic        ready;
    logic [31:0] elem_value;
    modport source (output valid, output elem_value, input ready);
    modport sink   (input valid, input elem_value, output ready);
endinterface

interface blm_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_value;
    logic        out_last;
    modport source (output valid, output out_value, output out_last, input ready);
    modport sink   (input valid, input out_value, input out_last, output ready);
endinterface

// ===== src/binomial_loss_matvec.sv =====
// ----------------------------------------------------------------------------
// binomial_loss_matvec
// binomial thinning transition table and matrix-vector product
// ----------------------------------------------------------------------------
// results start once the last element of a vector is taken; they are computed
// one at a time by the one shared mac, and no element is taken until the last result beat is issued
// each element beat is taken in one cycle while the block waits for a vector and no rebuild is pending
// reset and each keep_prob write rebuild the table, with element ready low;
// config writes are still taken
module binomial_loss_matvec import blm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    blm_elem_if.sink          i_elem,
    blm_res_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cmd cmd;
    t_sts sts;

    blm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    blm_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_elem  (i_elem),
        .o_res   (o_res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

endmodule

// ===== src/blm_ram.sv =====
// ----------------------------------------------------------------------------
// blm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module blm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/blm_ctrl.sv =====
// ----------------------------------------------------------------------------
// blm_ctrl
// sequencer for table build, element load and matrix-vector walk
// ----------------------------------------------------------------------------
module blm_ctrl import blm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_build_req, n_build_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BINIT;
            r_build_req <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_build_req <= n_build_req;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_build_req = r_build_req | i_sts.kp_wr;
        o_cmd       = '0;
        unique case (r_state)
            S_BINIT: begin
                o_cmd.b_init = 1'b1;
                n_state      = S_BRD;
            end
            S_BRD: begin
                o_cmd.b_rd_sel = 1'b1;
                n_state        = S_BM0;
            end
            S_BM0: begin
                o_cmd.b_mul0 = 1'b1;
                n_state      = S_BM1;
            end
            S_BM1: begin
                o_cmd.b_mul1 = 1'b1;
                n_state      = S_BM2;
            end
            S_BM2: begin
                o_cmd.b_wr = 1'b1;
                n_state    = (i_sts.row_last && i_sts.table_last) ? S_IDLE : S_BRD;
            end
            S_IDLE: begin
                if (r_build_req) begin
                    n_build_req = i_sts.kp_wr;
                    n_state     = S_BINIT;
                end else begin
                    o_cmd.in_en = 1'b1;
                    if (i_sts.in_valid && i_sts.vec_done) begin
                        o_cmd.m_start = 1'b1;
                        n_state       = S_MRD;
                    end
                end
            end
            S_MRD: begin
                n_state = S_MMUL;
            end
            S_MMUL: begin
                o_cmd.m_mul = 1'b1;
                n_state     = S_MACC;
            end
            S_MACC: begin
                o_cmd.m_acc = 1'b1;
                n_state     = i_sts.from_last ? S_MOUT : S_MMUL;
            end
            S_MOUT: begin
                if (i_sts.slot_free) begin
                    o_cmd.m_out = 1'b1;
                    n_state     = i_sts.out_last ? S_IDLE : S_MRD;
                end
            end
            default: begin
                n_state = S_BINIT;
            end
        endcase
    end

endmodule

// ===== src/blm_dp.sv =====
// ----------------------------------------------------------------------------
// blm_dp
// registers, table and vector rams, shared multiplier and accumulator
// ----------------------------------------------------------------------------
module blm_dp import blm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    blm_elem_if.sink          i_elem,
    blm_res_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [PROB_W-1:0] r_keep_prob;
    logic [VLEN_W-1:0] r_vec_len;
    logic [LEN_W-1:0]  r_lc, r_len, eff_len;
    logic [IDX_W-1:0]  r_i, r_j, r_to, r_from;
    logic [TAB_AW-1:0] r_cur_base, r_prev_base, r_addr, r_diag;
    logic [PROB_W-1:0] r_hold_old, r_hold_new;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic              r_last_from;
    logic              r_out_valid, r_out_last;
    logic [VAL_W-1:0]  r_out_value;

    logic              cfg_wr, accept;
    logic [PROB_W-1:0] q_eff, p_eff, b_wdata;
    logic [PROB_W-1:0] mul_a;
    logic [VAL_W-1:0]  mul_b;
    logic [ACC_W-1:0]  b_sum, m_sum;
    logic [RND_W-1:0]  b_rnd, m_rnd;
    logic [VAL_W-1:0]  m_sat;
    logic [TAB_AW-1:0] tab_raddr, tab_waddr;
    logic [PROB_W-1:0] tab_rdata;
    logic [VAL_W-1:0]  vec_rdata;
    logic              tab_we, out_take;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_prob <= ONE_Q16;
            r_vec_len   <= VLEN_W'(64);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_KEEP_PROB: r_keep_prob <= pwdata[PROB_W-1:0];
                REG_VEC_LEN:   r_vec_len   <= pwdata[VLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_KEEP_PROB: prdata = 32'(r_keep_prob);
            REG_VEC_LEN:   prdata = 32'(r_vec_len);
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        if (r_vec_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (int'(r_vec_len) > MAX_LEN) begin
            eff_len = LEN_W'(MAX_LEN);
        end else begin
            eff_len = LEN_W'(r_vec_len);
        end
    end

    assign q_eff = (r_keep_prob > ONE_Q16) ? ONE_Q16 : r_keep_prob;
    assign p_eff = ONE_Q16 - q_eff;

    // shared multiplier operands
    always_comb begin
        mul_a = tab_rdata;
        mul_b = vec_rdata;
        if (i_cmd.b_mul0) begin
            mul_a = (r_j < r_i) ? tab_rdata : '0;
            mul_b = VAL_W'(q_eff);
        end else if (i_cmd.b_mul1) begin
            mul_a = r_hold_old;
            mul_b = VAL_W'(p_eff);
        end
    end

    assign b_sum   = r_acc + ACC_W'(r_prod);
    assign b_rnd   = RND_W'((b_sum + HALF_Q16) >> 16);
    assign b_wdata = (b_rnd > RND_W'(ONE_Q16)) ? ONE_Q16 : PROB_W'(b_rnd);

    assign m_sum = r_acc;
    assign m_rnd = RND_W'((m_sum + HALF_Q16) >> 16);
    assign m_sat = (|m_rnd[RND_W-1:VAL_W]) ? '1 : m_rnd[VAL_W-1:0];

    assign accept   = i_cmd.in_en && i_elem.valid;
    assign out_take = r_out_valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_lc <= o_sts.vec_done ? '0 : r_lc + LEN_W'(1);
            end
            if (i_cmd.m_out) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.b_init) begin
            r_i         <= IDX_W'(1);
            r_j         <= '0;
            r_cur_base  <= TAB_AW'(1);
            r_prev_base <= '0;
            r_hold_old  <= '0;
        end
        if (i_cmd.b_mul0) begin
            r_hold_new <= tab_rdata;
        end
        if (i_cmd.b_mul1) begin
            r_acc <= ACC_W'(r_prod);
        end
        if (i_cmd.b_mul0 || i_cmd.b_mul1 || i_cmd.m_mul) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (i_cmd.b_wr) begin
            if (r_j == r_i) begin
                r_i         <= r_i + IDX_W'(1);
                r_j         <= '0;
                r_prev_base <= r_cur_base;
                r_cur_base  <= r_cur_base + TAB_AW'(r_i) + TAB_AW'(1);
                r_hold_old  <= '0;
            end else begin
                r_j        <= r_j + IDX_W'(1);
                r_hold_old <= r_hold_new;
            end
        end
        if (i_cmd.m_start) begin
            r_len  <= eff_len;
            r_to   <= '0;
            r_from <= '0;
            r_addr <= '0;
            r_diag <= '0;
            r_acc  <= '0;
        end
        if (i_cmd.m_mul) begin
            r_last_from <= (LEN_W'(r_from) + LEN_W'(1)) >= r_len;
            if ((LEN_W'(r_from) + LEN_W'(1)) < r_len) begin
                r_from <= r_from + IDX_W'(1);
                r_addr <= r_addr + TAB_AW'(r_from) + TAB_AW'(1);
            end
        end
        if (i_cmd.m_acc) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.m_out) begin
            r_out_value <= m_sat;
            r_out_last  <= o_sts.out_last;
            r_acc       <= '0;
            r_to        <= r_to + IDX_W'(1);
            r_from      <= r_to + IDX_W'(1);
            r_diag      <= r_diag + TAB_AW'(r_to) + TAB_AW'(2);
            r_addr      <= r_diag + TAB_AW'(r_to) + TAB_AW'(2);
        end
    end

    assign tab_raddr = i_cmd.b_rd_sel ? r_prev_base + TAB_AW'(r_j) : r_addr;
    assign tab_waddr = i_cmd.b_init ? '0 : r_cur_base + TAB_AW'(r_j);
    assign tab_we    = i_cmd.b_init || i_cmd.b_wr;

    blm_ram #(.WIDTH(PROB_W), .DEPTH(TAB_DEPTH)) u_tab (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (i_cmd.b_init ? ONE_Q16 : b_wdata),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    blm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_vec (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_lc[IDX_W-1:0]),
        .i_wdata (i_elem.elem_value),
        .i_raddr (r_from),
        .o_rdata (vec_rdata)
    );

    assign i_elem.ready    = i_cmd.in_en;
    assign o_res.valid     = r_out_valid;
    assign o_res.out_value = r_out_value;
    assign o_res.out_last  = r_out_last;

    assign o_sts.in_valid   = i_elem.valid;
    assign o_sts.kp_wr      = cfg_wr && (paddr[2] == REG_KEEP_PROB);
    assign o_sts.vec_done   = (r_lc + LEN_W'(1)) >= eff_len;
    assign o_sts.row_last   = (r_j == r_i);
    assign o_sts.table_last = (r_i == IDX_W'(MAX_LEN - 1));
    assign o_sts.from_last  = r_last_from;
    assign o_sts.out_last   = (LEN_W'(r_to) + LEN_W'(1)) == r_len;
    assign o_sts.slot_free  = !r_out_valid || o_res.ready;

endmodule

// ===== src/blm_chk.sv =====
// ----------------------------------------------------------------------------
// blm_chk
// port-level checks for binomial_loss_matvec
// ----------------------------------------------------------------------------
module blm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_value,
    input logic        i_out_last,
    input logic        i_pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_value) && $stable(i_out_last))
        else $error("stalled result beat changed");

    a_busy_mid_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("element taken while a vector is still being emitted");

    a_build_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("element ready during table build after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready dropped");

endmodule

bind binomial_loss_matvec blm_chk u_blm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_elem.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_value (o_res.out_value),
    .i_out_last  (o_res.out_last),
    .i_pready    (pready)
);

// ===== tb/sv/binomial_loss_matvec_test.sv =====
// ----------------------------------------------------------------------------
// binomial_loss_matvec_test
// drives element beats and register writes into the binomial transition block,
// predicts each output vector from its own copy of the table and compares
// every result beat in order, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module binomial_loss_matvec_test;
    import blm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int NUM_ITEMS   = 180;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             last;
    } t_res_beat;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    blm_elem_if elem_ch();
    blm_res_if  res_ch();

    binomial_loss_matvec dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_elem  (elem_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [PROB_W-1:0] thin_table [TAB_DEPTH];
    logic [VAL_W-1:0]  elem_buf [MAX_LEN];
    int unsigned       elem_count;
    logic [PROB_W-1:0] keep_q;
    logic [VLEN_W-1:0] len_reg;

    logic [VAL_W-1:0] elem_feed [$];
    t_res_beat        pending_res [$];
    int               fails;
    int               pushed;
    int               accepted;
    int               beats_seen;
    int               cycles;
    int               gap_cnt;
    int               stall_cnt;
    int               hold_cnt;
    bit               hold_done;

    function automatic int row_start(int r);
        return r * (r + 1) / 2;
    endfunction

    function automatic logic [PROB_W-1:0] round_prob(longint unsigned acc);
        longint unsigned r;
        r = (acc + 32768) >> 16;
        return (r > 65536) ? ONE_Q16 : PROB_W'(r);
    endfunction

    function automatic void build_thin_table();
        longint unsigned q;
        longint unsigned p;
        int cur;
        int prv;
        q = (keep_q > ONE_Q16) ? 65536 : keep_q;
        p = 65536 - q;
        thin_table[0] = ONE_Q16;
        for (int i = 1; i < MAX_LEN; i++) begin
            cur = row_start(i);
            prv = row_start(i - 1);
            thin_table[cur] = round_prob(thin_table[prv] * q);
            for (int j = 1; j < i; j++) begin
                thin_table[cur + j] = round_prob(thin_table[prv + j] * q
                                                 + thin_table[prv + j - 1] * p);
            end
            thin_table[cur + i] = round_prob(thin_table[prv + i - 1] * p);
        end
    endfunction

    function automatic int eff_len();
        if (len_reg == 0) return 1;
        if (len_reg > MAX_LEN) return MAX_LEN;
        return len_reg;
    endfunction

    function automatic void absorb_elem(logic [VAL_W-1:0] v);
        int len;
        longint unsigned acc;
        longint unsigned r;
        t_res_beat b;
        len = eff_len();
        if (elem_count < MAX_LEN) elem_buf[elem_count] = v;
        elem_count++;
        if (elem_count >= len) begin
            for (int t = 0; t < len; t++) begin
                acc = 0;
                for (int f = t; f < len; f++) begin
                    acc += longint'(thin_table[row_start(f) + t]) * elem_buf[f];
                end
                r = (acc + 32768) >> 16;
                b.value = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : VAL_W'(r);
                b.last  = (t + 1 == len);
                pending_res.push_back(b);
            end
            elem_count = 0;
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // element driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            elem_ch.valid      <= 1'b0;
            elem_ch.elem_value <= '0;
            gap_cnt            <= 0;
        end else if (!elem_ch.valid || elem_ch.ready) begin
            if (elem_ch.valid && elem_ch.ready) begin
                absorb_elem(elem_ch.elem_value);
                accepted <= accepted + 1;
            end
            if (gap_cnt > 0) begin
                elem_ch.valid <= 1'b0;
                gap_cnt       <= gap_cnt - 1;
            end else if (elem_feed.size() > 0) begin
                elem_ch.valid      <= 1'b1;
                elem_ch.elem_value <= elem_feed.pop_front();
                case ($urandom_range(0, 19))
                    0, 1, 2, 3: gap_cnt <= $urandom_range(1, 3);
                    4:          gap_cnt <= $urandom_range(10, 40);
                    default:    gap_cnt <= 0;
                endcase
            end else begin
                elem_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_res_beat exp_b;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_cnt    <= 0;
            hold_cnt     <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                beats_seen <= beats_seen + 1;
                if (pending_res.size() == 0) begin
                    $error("unexpected result beat value %h last %b",
                           res_ch.out_value, res_ch.out_last);
                    fails++;
                end else begin
                    exp_b = pending_res.pop_front();
                    if (res_ch.out_value !== exp_b.value) begin
                        $error("out_value expected %h actual %h", exp_b.value,
                               res_ch.out_value);
                        fails++;
                    end
                    if (res_ch.out_last !== exp_b.last) begin
                        $error("out_last expected %b actual %b", exp_b.last,
                               res_ch.out_last);
                        fails++;
                    end
                end
            end
            if (!hold_done && beats_seen == 16) begin
                hold_done    <= 1'b1;
                hold_cnt     <= 600;
                res_ch.ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt     <= hold_cnt - 1;
                res_ch.ready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt    <= stall_cnt - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                case ($urandom_range(0, 19))
                    0, 1, 2: stall_cnt <= $urandom_range(1, 3);
                    3:       stall_cnt <= $urandom_range(10, 40);
                    default: stall_cnt <= 0;
                endcase
            end
        end
    end

    task automatic reg_write(input int idx, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == int'(REG_KEEP_PROB)) begin
            keep_q = data[PROB_W-1:0];
            build_thin_table();
        end else if (idx == int'(REG_VEC_LEN)) begin
            len_reg = data[VLEN_W-1:0];
        end
    endtask

    task automatic wait_drained();
        while (accepted != pushed || pending_res.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_elem(input logic [VAL_W-1:0] v);
        elem_feed.push_back(v);
        pushed++;
    endtask

    function automatic logic [VAL_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0;
            2:       return VAL_W'($urandom_range(0, 255));
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int len;
        int nvec;
        int kp;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        elem_ch.valid = 1'b0; elem_ch.elem_value = '0; res_ch.ready = 1'b0;
        fails = 0; pushed = 0; accepted = 0; beats_seen = 0; cycles = 0;
        gap_cnt = 0; stall_cnt = 0; hold_cnt = 0; hold_done = 1'b0;
        keep_q = ONE_Q16; len_reg = 7'd64; elem_count = 0;
        build_thin_table();
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single elements, clamps, saturation, mid probability
        reg_write(int'(REG_VEC_LEN), 32'd1);
        send_elem(32'h0);
        send_elem(32'hFFFF_FFFF);
        wait_drained();
        reg_write(int'(REG_KEEP_PROB), 32'h1FFFF);
        reg_write(int'(REG_VEC_LEN), 32'd0);
        send_elem(32'h8000_0001);
        wait_drained();
        reg_write(int'(REG_KEEP_PROB), 32'd0);
        reg_write(int'(REG_VEC_LEN), 32'd3);
        repeat (3) send_elem(32'hFFFF_FFFF);
        wait_drained();
        reg_write(int'(REG_KEEP_PROB), 32'd65536);
        repeat (3) send_elem(32'hFFFF_FFFF);
        wait_drained();
        reg_write(int'(REG_KEEP_PROB), 32'd32768);
        reg_write(int'(REG_VEC_LEN), 32'd4);
        send_elem(32'h4000_0000);
        send_elem(32'h0000_0001);
        send_elem(32'h5555_5555);
        send_elem(32'hAAAA_AAAA);
        wait_drained();
        // receiver hold-off lands here while elements keep coming
        reg_write(int'(REG_VEC_LEN), 32'd8);
        repeat (16) send_elem(rand_elem());
        wait_drained();

        // random phases
        while (pushed < NUM_ITEMS) begin
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 9))
                    0:       kp = 0;
                    1:       kp = 65536;
                    2:       kp = 131071;
                    default: kp = $urandom_range(0, 65536);
                endcase
                reg_write(int'(REG_KEEP_PROB), 32'(kp));
            end
            case ($urandom_range(0, 19))
                0:       len = 64;
                1:       len = 0;
                2:       len = 127;
                default: len = $urandom_range(1, 8);
            endcase
            reg_write(int'(REG_VEC_LEN), 32'(len));
            len  = eff_len();
            nvec = (len == MAX_LEN) ? 1 : $urandom_range(1, 4);
            repeat (nvec * len) send_elem(rand_elem());
            wait_drained();
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/blm_pkg.sv
src/blm_if.sv
src/blm_ram.sv
src/blm_ctrl.sv
src/blm_dp.sv
src/binomial_loss_matvec.sv
src/blm_chk.sv
tb/sv/binomial_loss_matvec_test.sv
